>>> src/jtfd_pkg.sv
// Package for the joystick/tilt frame deframer.
// Byte codes, mode codes, result bit positions and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jtfd_pkg;

  // Byte codes
  localparam logic [7:0] CH_LO_A    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_B    = 8'h62;  // 'b'
  localparam logic [7:0] CH_LO_F    = 8'h66;  // 'f'
  localparam logic [7:0] CH_LO_G    = 8'h67;  // 'g'
  localparam logic [7:0] CH_LEFT    = 8'h4C;  // 'L'
  localparam logic [7:0] CH_RIGHT   = 8'h52;  // 'R'
  localparam logic [7:0] CH_TILT    = 8'h41;  // 'A'
  localparam logic [7:0] CH_END     = 8'h2A;  // '*'

  // Mode codes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_REMOTE = 2'd1;
  localparam logic [1:0] MODE_TILT   = 2'd2;

  // Default frame capacities
  localparam int STICK_FRAME_MAX_DEF = 10;
  localparam int TILT_FRAME_MAX_DEF  = 20;

  // Result word layout
  localparam int OUT_W        = 24;
  localparam int B_MODE_LO    = 0;
  localparam int B_DATA_LO    = 2;
  localparam int B_LEFT_TAKE  = 10;
  localparam int B_LEFT_END   = 11;
  localparam int B_RIGHT_TAKE = 12;
  localparam int B_RIGHT_END  = 13;
  localparam int B_TILT_TAKE  = 14;
  localparam int B_TILT_END   = 15;
  localparam int B_TILT_BEGIN = 16;
  localparam int B_LEFT_CUT   = 17;
  localparam int B_RIGHT_CUT  = 18;
  localparam int B_TILT_CUT   = 19;

  // Per-byte control into one frame channel
  typedef struct packed {
    logic step;      // byte transfer that this channel sees
    logic open;      // header byte for this channel
    logic restart;   // header also clears count and drop mark
    logic excluded;  // byte never belongs to a frame
    logic is_end;    // end marker
  } jtfd_ctl_t;

  // Per-byte status out of one frame channel
  typedef struct packed {
    logic take;
    logic ended;
    logic cut;
  } jtfd_sts_t;

endpackage

`default_nettype wire

>>> src/jtfd_chan.sv
// One frame channel: open flag, saturating byte count and drop mark.
// Depends on jtfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtfd_chan
  import jtfd_pkg::*;
#(
  parameter int CAP = STICK_FRAME_MAX_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire jtfd_ctl_t ctl,
  output jtfd_sts_t      sts
);

  localparam int CNT_W = $clog2(CAP + 1);

  logic             active_r, active_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             mark_r, mark_nxt;

  logic             act_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic             mark_eff;

  always_comb begin
    act_eff    = active_r | ctl.open;
    cnt_eff    = ctl.restart ? '0 : count_r;
    mark_eff   = ctl.restart ? 1'b0 : mark_r;
    active_nxt = active_r;
    count_nxt  = count_r;
    mark_nxt   = mark_r;
    sts        = '0;
    if (ctl.step) begin
      active_nxt = act_eff;
      count_nxt  = cnt_eff;
      mark_nxt   = mark_eff;
      if (act_eff && !ctl.excluded) begin
        if (ctl.is_end) begin
          sts.take   = 1'b1;
          sts.ended  = 1'b1;
          sts.cut    = mark_eff;
          mark_nxt   = 1'b0;
          count_nxt  = '0;
          active_nxt = 1'b0;
        end else if (cnt_eff < CNT_W'(CAP)) begin
          sts.take  = 1'b1;
          count_nxt = cnt_eff + 1'b1;
        end else begin
          mark_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
      mark_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      mark_r   <= mark_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/joystick_tilt_frame_deframer.sv
// Top level of the joystick/tilt frame deframer.
// Depends on jtfd_pkg and jtfd_chan.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received serial byte per transfer and returns one result word per
// byte. Unless the output stalls, a byte can be accepted in every cycle: the
// frame state updates at the input transfer and the result sits in
// a single output register, which may be reloaded in the cycle it is taken.
// Bytes 'a'..'g' set the mode ('b' tilt, the rest remote). In remote mode,
// and before any mode byte, 'L' and 'R' open left and right stick frames that
// run to '*'; the first completed frame on each stick is not reported. In tilt
// mode 'A' (re)starts the tilt frame. Bytes beyond a frame's capacity are
// dropped and reported as a cut on the closing '*'.

module joystick_tilt_frame_deframer
  import jtfd_pkg::*;
#(
  parameter int STICK_FRAME_MAX = STICK_FRAME_MAX_DEF,
  parameter int TILT_FRAME_MAX  = TILT_FRAME_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // [1:0] mode, [9:2] data, [10] left_take, [11] left_end, [12] right_take,
  // [13] right_end, [14] tilt_take, [15] tilt_end, [16] tilt_begin,
  // [17] left_cut, [18] right_cut, [19] tilt_cut, [23:20] zero
  output logic [OUT_W-1:0]      out_tdata
);

  logic             in_xfer;
  logic [7:0]       b;
  logic             excluded;
  logic [1:0]       mode_r, mode_nxt;
  logic             lfd_r, lfd_nxt;
  logic             rfd_r, rfd_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  jtfd_ctl_t left_ctl, right_ctl, tilt_ctl;
  jtfd_sts_t left_sts, right_sts, tilt_sts;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign excluded  = (b >= CH_LO_A) && (b <= CH_LO_F);

  always_comb begin
    mode_nxt = mode_r;
    if (b == CH_LO_B) begin
      mode_nxt = MODE_TILT;
    end else if (b >= CH_LO_A && b <= CH_LO_G) begin
      mode_nxt = MODE_REMOTE;
    end
  end

  always_comb begin
    left_ctl.step     = in_xfer && (mode_nxt != MODE_TILT);
    left_ctl.open     = (b == CH_LEFT);
    left_ctl.restart  = 1'b0;
    left_ctl.excluded = excluded;
    left_ctl.is_end   = (b == CH_END);

    right_ctl.step     = in_xfer && (mode_nxt != MODE_TILT);
    right_ctl.open     = (b == CH_RIGHT);
    right_ctl.restart  = 1'b0;
    right_ctl.excluded = excluded;
    right_ctl.is_end   = (b == CH_END);

    tilt_ctl.step     = in_xfer && (mode_nxt == MODE_TILT);
    tilt_ctl.open     = (b == CH_TILT);
    tilt_ctl.restart  = (b == CH_TILT);
    tilt_ctl.excluded = excluded;
    tilt_ctl.is_end   = (b == CH_END);
  end

  jtfd_chan #(.CAP(STICK_FRAME_MAX)) u_left (
    .clk(clk), .rst_n(rst_n), .ctl(left_ctl), .sts(left_sts)
  );

  jtfd_chan #(.CAP(STICK_FRAME_MAX)) u_right (
    .clk(clk), .rst_n(rst_n), .ctl(right_ctl), .sts(right_sts)
  );

  jtfd_chan #(.CAP(TILT_FRAME_MAX)) u_tilt (
    .clk(clk), .rst_n(rst_n), .ctl(tilt_ctl), .sts(tilt_sts)
  );

  // The first completed stick frame only arms the first-done flag.
  assign lfd_nxt = lfd_r | left_sts.ended;
  assign rfd_nxt = rfd_r | right_sts.ended;

  always_comb begin
    out_tdata_nxt                          = '0;
    out_tdata_nxt[B_MODE_LO +: 2]          = mode_nxt;
    out_tdata_nxt[B_DATA_LO +: 8]          = b;
    out_tdata_nxt[B_LEFT_TAKE]             = lfd_r & left_sts.take;
    out_tdata_nxt[B_LEFT_END]              = lfd_r & left_sts.ended;
    out_tdata_nxt[B_LEFT_CUT]              = lfd_r & left_sts.cut;
    out_tdata_nxt[B_RIGHT_TAKE]            = rfd_r & right_sts.take;
    out_tdata_nxt[B_RIGHT_END]             = rfd_r & right_sts.ended;
    out_tdata_nxt[B_RIGHT_CUT]             = rfd_r & right_sts.cut;
    out_tdata_nxt[B_TILT_TAKE]             = tilt_sts.take;
    out_tdata_nxt[B_TILT_END]              = tilt_sts.ended;
    out_tdata_nxt[B_TILT_CUT]              = tilt_sts.cut;
    out_tdata_nxt[B_TILT_BEGIN]            = (mode_nxt == MODE_TILT) && (b == CH_TILT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NONE;
      lfd_r       <= 1'b0;
      rfd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_r <= mode_nxt;
        lfd_r  <= lfd_nxt;
        rfd_r  <= rfd_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // Once a mode byte has arrived the mode never falls back to none.
  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_NONE) |=> (mode_r != MODE_NONE))
    else $error("mode returned to none");

  // A reported left end needs the first left frame already discarded.
  a_left_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tdata_r[B_LEFT_END]) |-> lfd_r)
    else $error("left end reported before first frame was discarded");

  // Tilt channel bits appear only with tilt mode.
  a_tilt_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_tdata_r[B_TILT_TAKE] || out_tdata_r[B_TILT_BEGIN]))
      |-> (out_tdata_r[B_MODE_LO +: 2] == MODE_TILT))
    else $error("tilt bits outside tilt mode");

  // Stick and tilt channels never claim the same byte.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_tdata_r[B_TILT_TAKE] &&
                      (out_tdata_r[B_LEFT_TAKE] || out_tdata_r[B_RIGHT_TAKE])))
    else $error("stick and tilt take the same byte");

  // A cut is only ever reported together with its end.
  a_cut_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_tdata_r[B_LEFT_CUT] || out_tdata_r[B_LEFT_END]) &&
                     (!out_tdata_r[B_RIGHT_CUT] || out_tdata_r[B_RIGHT_END]) &&
                     (!out_tdata_r[B_TILT_CUT] || out_tdata_r[B_TILT_END])))
    else $error("cut without end");
`endif

endmodule

`default_nettype wire

>>> bench/joystick_tilt_frame_deframer_tb.sv
// Testbench for joystick_tilt_frame_deframer: streams serial bytes in, checks
// every result word against a behavioral predictor kept in a small scoreboard class.
// Depends on jtfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module joystick_tilt_frame_deframer_tb;
  import jtfd_pkg::*;

  localparam int STICK_CAP      = STICK_FRAME_MAX_DEF;
  localparam int TILT_CAP       = TILT_FRAME_MAX_DEF;
  localparam int BYTE_COUNT     = 1100;
  localparam int CALM_TAIL      = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic       left_take;
    logic       left_end;
    logic       right_take;
    logic       right_end;
    logic       tilt_take;
    logic       tilt_end;
    logic       tilt_begin;
    logic       left_cut;
    logic       right_cut;
    logic       tilt_cut;
  } frame_tag_t;

  class deframe_scoreboard;
    logic [1:0] mode_q;
    bit         left_open, right_open, tilt_open;
    bit         left_seen_first, right_seen_first;
    int         left_len, right_len, tilt_len;
    bit [2:0]   drop_marks;
    frame_tag_t pending_tags[$];
    int         errors;

    function new();
      mode_q = MODE_NONE;
      left_open = 0;
      right_open = 0;
      tilt_open = 0;
      left_seen_first = 0;
      right_seen_first = 0;
      left_len = 0;
      right_len = 0;
      tilt_len = 0;
      drop_marks = '0;
      errors = 0;
    endfunction

    // One byte into an open frame; returns 1 if stored or if it closes the frame.
    function bit feed(input logic [7:0] b, inout int len, input int cap, input int mark,
                      output bit ended, output bit cut);
      ended = 0;
      cut = 0;
      if (b == CH_END) begin
        ended = 1;
        cut = drop_marks[mark];
        drop_marks[mark] = 0;
        len = 0;
        return 1;
      end
      if (len < cap) begin
        len++;
        return 1;
      end
      drop_marks[mark] = 1;
      return 0;
    endfunction

    function void note_byte(input logic [7:0] b);
      frame_tag_t r;
      bit excl, ended, cut, t;
      r = '0;
      excl = (b >= CH_LO_A) && (b <= CH_LO_F);
      if (b == CH_LO_B) mode_q = MODE_TILT;
      else if (b >= CH_LO_A && b <= CH_LO_G) mode_q = MODE_REMOTE;

      if (mode_q != MODE_TILT) begin
        if (b == CH_LEFT) left_open = 1;
        if (left_open && !excl) begin
          t = feed(b, left_len, STICK_CAP, 0, ended, cut);
          // first completed frame per stick is swallowed
          if (left_seen_first) begin
            r.left_take = t;
            r.left_end = ended;
            r.left_cut = ended && cut;
          end
          if (ended) begin
            left_seen_first = 1;
            left_open = 0;
          end
        end
        if (b == CH_RIGHT) right_open = 1;
        if (right_open && !excl) begin
          t = feed(b, right_len, STICK_CAP, 1, ended, cut);
          if (right_seen_first) begin
            r.right_take = t;
            r.right_end = ended;
            r.right_cut = ended && cut;
          end
          if (ended) begin
            right_seen_first = 1;
            right_open = 0;
          end
        end
      end else begin
        if (b == CH_TILT) begin
          tilt_open = 1;
          tilt_len = 0;
          drop_marks[2] = 0;
          r.tilt_begin = 1;
        end
        if (tilt_open && !excl) begin
          t = feed(b, tilt_len, TILT_CAP, 2, ended, cut);
          r.tilt_take = t;
          r.tilt_end = ended;
          r.tilt_cut = ended && cut;
          if (ended) tilt_open = 0;
        end
      end
      r.mode = mode_q;
      r.data = b;
      pending_tags.push_back(r);
    endfunction

    function void check_result(input logic [OUT_W-1:0] w);
      frame_tag_t got, want;
      bit bad;
      got.mode       = w[B_MODE_LO +: 2];
      got.data       = w[B_DATA_LO +: 8];
      got.left_take  = w[B_LEFT_TAKE];
      got.left_end   = w[B_LEFT_END];
      got.right_take = w[B_RIGHT_TAKE];
      got.right_end  = w[B_RIGHT_END];
      got.tilt_take  = w[B_TILT_TAKE];
      got.tilt_end   = w[B_TILT_END];
      got.tilt_begin = w[B_TILT_BEGIN];
      got.left_cut   = w[B_LEFT_CUT];
      got.right_cut  = w[B_RIGHT_CUT];
      got.tilt_cut   = w[B_TILT_CUT];
      if (pending_tags.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", w);
        return;
      end
      want = pending_tags.pop_front();
      bad = (got !== want) || (w[OUT_W-1:B_TILT_CUT+1] !== '0);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display({"mismatch byte %h: exp mode=%0d take(L,R,T)=%b%b%b",
                    " end=%b%b%b begin=%b cut=%b%b%b"},
                   want.data, want.mode, want.left_take, want.right_take, want.tilt_take,
                   want.left_end, want.right_end, want.tilt_end, want.tilt_begin,
                   want.left_cut, want.right_cut, want.tilt_cut);
          $display({"  got data=%h mode=%0d take(L,R,T)=%b%b%b",
                    " end=%b%b%b begin=%b cut=%b%b%b pad=%h"},
                   got.data, got.mode, got.left_take, got.right_take, got.tilt_take,
                   got.left_end, got.right_end, got.tilt_end, got.tilt_begin,
                   got.left_cut, got.right_cut, got.tilt_cut, w[OUT_W-1:B_TILT_CUT+1]);
        end
      end
    endfunction

    function int pending();
      return pending_tags.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  deframe_scoreboard sb;
  int sent_bytes;
  int in_gap_pct;
  int out_stall_pct;
  int stall_left = 0;
  int quiet_cycles = 0;

  joystick_tilt_frame_deframer #(
    .STICK_FRAME_MAX(STICK_CAP),
    .TILT_FRAME_MAX (TILT_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    sent_bytes++;
  endtask

  // Per-sequence idling level; some stretches run with none at all.
  task automatic pick_pace();
    if (sent_bytes >= BYTE_COUNT - CALM_TAIL) begin
      in_gap_pct = 0;
      out_stall_pct = 0;
    end else begin
      case ($urandom_range(0, 3))
        0: in_gap_pct = 0;
        1: in_gap_pct = 5;
        2: in_gap_pct = 15;
        default: in_gap_pct = 40;
      endcase
      case ($urandom_range(0, 3))
        0: out_stall_pct = 0;
        1: out_stall_pct = 5;
        2: out_stall_pct = 15;
        default: out_stall_pct = 30;
      endcase
    end
  endtask

  function automatic logic [7:0] remote_mode_byte();
    logic [7:0] v;
    v = 8'($urandom_range(CH_LO_A, CH_LO_G));
    if (v == CH_LO_B) v = CH_LO_G;
    return v;
  endfunction

  // Frame content: mostly arbitrary bytes other than the end marker, with a
  // sprinkling of headers and mode bytes to break the sequence now and then.
  function automatic logic [7:0] payload_byte();
    logic [7:0] v;
    case ($urandom_range(0, 29))
      0: v = CH_LEFT;
      1: v = CH_RIGHT;
      2: v = CH_TILT;
      3: v = 8'($urandom_range(CH_LO_A, CH_LO_G));
      default: begin
        v = 8'($urandom_range(0, 255));
        if (v == CH_END) v = v + 8'd1;
      end
    endcase
    return v;
  endfunction

  task automatic stick_frame();
    logic [7:0] hdr, other;
    int n;
    if (sb.mode_q == MODE_TILT || $urandom_range(0, 2) == 0) send_byte(remote_mode_byte());
    hdr = $urandom_range(0, 1) ? CH_LEFT : CH_RIGHT;
    other = (hdr == CH_LEFT) ? CH_RIGHT : CH_LEFT;
    send_byte(hdr);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_byte(other);  // overlapping frame
      else send_byte(payload_byte());
    end
    if ($urandom_range(0, 9) != 0) send_byte(CH_END);
  endtask

  task automatic tilt_frame();
    int n;
    if (sb.mode_q != MODE_TILT || $urandom_range(0, 3) == 0) send_byte(CH_LO_B);
    send_byte(CH_TILT);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 25) : $urandom_range(0, 12);
    repeat (n) send_byte(payload_byte());
    if ($urandom_range(0, 9) != 0) send_byte(CH_END);
  endtask

  task automatic line_noise();
    logic [7:0] v;
    repeat ($urandom_range(1, 8)) begin
      v = ($urandom_range(0, 5) == 0) ? CH_END : 8'($urandom_range(0, 255));
      send_byte(v);
    end
  endtask

  initial begin
    logic [7:0] opening[$];
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    sent_bytes = 0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first frames swallowed, overlap, repeated header, excluded byte,
    // both stick frames running past capacity and closing when full, tilt restart.
    opening = '{8'h00, 8'hFF, CH_LEFT, CH_END, CH_RIGHT, CH_END,
                CH_LEFT, CH_RIGHT, CH_LEFT, CH_LO_A,
                8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                CH_END, CH_LO_B, CH_TILT, CH_TILT, CH_END, CH_LO_G};
    in_gap_pct = 20;
    out_stall_pct = 20;
    foreach (opening[i]) send_byte(opening[i]);

    while (sent_bytes < BYTE_COUNT) begin
      pick_pace();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: stick_frame();
        4, 5, 6:    tilt_frame();
        default:    line_noise();
      endcase
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/jtfd_pkg.sv
src/jtfd_chan.sv
src/joystick_tilt_frame_deframer.sv
bench/joystick_tilt_frame_deframer_tb.sv
